>>> rtl/button_debounce_autorepeat_assert.svh
// Assertion macros shared by the button debounce RTL.
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_ASSERT_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_ASSERT_SVH

`ifndef SYNTHESIS
`define BDA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BDA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BDA_ASSERT_IMP(label, ante, cons, msg)
`define BDA_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/bda_pkg.sv
// Shared types and constants for the button debounce and auto-repeat block.
package bda_pkg;

	localparam int LANES_MAX       = 4;
	localparam int PIN_W           = 4;
	localparam int DEB_W           = 10;
	localparam int HOLD_W          = 16;
	localparam int IDX_W           = 2;
	localparam int KIND_W          = 2;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;
	localparam int DEF_NUM_BUTTONS = 4;

	localparam logic [DEB_W-1:0]  DEF_DEBOUNCE = DEB_W'(15);
	localparam logic [HOLD_W-1:0] DEF_LONG     = HOLD_W'(500);
	localparam logic [HOLD_W-1:0] DEF_PERIOD   = HOLD_W'(200);
	localparam logic [HOLD_W-1:0] HOLD_MAX     = '1;

	localparam logic CMD_TICK       = 1'b0;
	localparam logic CMD_PIN_CHANGE = 1'b1;

	localparam logic [KIND_W-1:0] KIND_PRESS   = KIND_W'(0);
	localparam logic [KIND_W-1:0] KIND_RELEASE = KIND_W'(1);
	localparam logic [KIND_W-1:0] KIND_REPEAT  = KIND_W'(2);

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LONG     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = CFG_IDX_W'(2);

	typedef struct packed {
		logic [LANES_MAX-1:0]             mask;
		logic [LANES_MAX-1:0][KIND_W-1:0] kind;
	} ev_t;

endpackage

>>> rtl/bda_core.sv
// Input register, debounce and hold state, and per-request event computation.
`include "button_debounce_autorepeat_assert.svh"
module bda_core import bda_pkg::*; #(
	parameter int NUM_BUTTONS = DEF_NUM_BUTTONS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic [PIN_W-1:0]      pin_levels,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  ev_ready,
	output logic                  ev_load,
	output ev_t                   ev
);

	localparam int LANES = (NUM_BUTTONS > LANES_MAX) ? LANES_MAX : NUM_BUTTONS;

	logic                   valid_s1;
	logic                   cmd_s1;
	logic [LANES-1:0]       pins_s1;

	logic [DEB_W-1:0]       deb_q;
	logic [HOLD_W-1:0]      long_q;
	logic [HOLD_W-1:0]      period_q;

	logic [LANES-1:0]              stable_q, stable_d;
	logic [DEB_W-1:0]              settle_q, settle_d;
	logic [LANES-1:0][HOLD_W-1:0]  hold_q, hold_d;
	logic [LANES-1:0]              rep_q, rep_d;
	logic [LANES-1:0][HOLD_W-1:0]  hinc;
	ev_t                           ev_c;
	logic                          advance;

	always_comb begin
		stable_d = stable_q;
		settle_d = settle_q;
		hold_d   = hold_q;
		rep_d    = rep_q;
		ev_c     = '0;
		for (int i = 0; i < LANES; i++) begin
			hinc[i] = (hold_q[i] == HOLD_MAX) ? hold_q[i] : hold_q[i] + HOLD_W'(1);
		end
		if (cmd_s1 == CMD_PIN_CHANGE) begin
			settle_d = deb_q;
			hold_d   = '0;
			rep_d    = '0;
		end else if (settle_q != '0) begin
			settle_d = settle_q - DEB_W'(1);
			if (settle_d == '0) begin
				for (int i = 0; i < LANES; i++) begin
					if (!pins_s1[i] != stable_q[i]) begin
						hold_d[i]   = '0;
						rep_d[i]    = 1'b0;
						stable_d[i] = !pins_s1[i];
						ev_c.mask[i] = 1'b1;
						ev_c.kind[i] = pins_s1[i] ? KIND_RELEASE : KIND_PRESS;
					end
				end
			end
		end else if (stable_q != '0) begin
			for (int i = 0; i < LANES; i++) begin
				if (!stable_q[i]) begin
					hold_d[i] = '0;
					rep_d[i]  = 1'b0;
				end else if (!rep_q[i]) begin
					hold_d[i] = hinc[i];
					if (hinc[i] >= long_q) begin
						rep_d[i]     = 1'b1;
						hold_d[i]    = '0;
						ev_c.mask[i] = 1'b1;
						ev_c.kind[i] = KIND_REPEAT;
					end
				end else begin
					hold_d[i] = hinc[i];
					if (hinc[i] >= period_q) begin
						hold_d[i]    = '0;
						ev_c.mask[i] = 1'b1;
						ev_c.kind[i] = KIND_REPEAT;
					end
				end
			end
		end
	end

	assign advance  = valid_s1 && ((ev_c.mask == '0) || ev_ready);
	assign ev_load  = advance && (ev_c.mask != '0);
	assign ev       = ev_c;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= cmd;
			pins_s1 <= pin_levels[LANES-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q    <= DEF_DEBOUNCE;
			long_q   <= DEF_LONG;
			period_q <= DEF_PERIOD;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEBOUNCE: deb_q    <= cfg_data[DEB_W-1:0];
				REG_LONG:     long_q   <= cfg_data[HOLD_W-1:0];
				REG_PERIOD:   period_q <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= '0;
			settle_q <= '0;
			hold_q   <= '0;
			rep_q    <= '0;
		end else if (advance) begin
			stable_q <= stable_d;
			settle_q <= settle_d;
			hold_q   <= hold_d;
			rep_q    <= rep_d;
		end
	end

	`BDA_ASSERT_NXT(a_pin_change_restart, advance && (cmd_s1 == CMD_PIN_CHANGE), (settle_q == $past(deb_q)) && (hold_q == '0) && (rep_q == '0), "pin change did not restart settling")
	`BDA_ASSERT_IMP(a_events_only_on_tick, ev_load, cmd_s1 == CMD_TICK, "events raised by a pin change")
	`BDA_ASSERT_NXT(a_idle_settle_stays, advance && (cmd_s1 == CMD_TICK) && (settle_q == '0), settle_q == '0, "countdown started on a tick")

endmodule

>>> rtl/bda_evq.sv
// Event register that hands out one event per cycle while out_ready is high, in ascending button order.
`include "button_debounce_autorepeat_assert.svh"
module bda_evq import bda_pkg::*; #(
	parameter int NUM_BUTTONS = DEF_NUM_BUTTONS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ev_load,
	input  ev_t               ev,
	output logic              ev_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IDX_W-1:0]  button_index,
	output logic [KIND_W-1:0] event_kind,
	output logic              last_event
);

	localparam int LANES = (NUM_BUTTONS > LANES_MAX) ? LANES_MAX : NUM_BUTTONS;

	logic [LANES-1:0]             mask_q;
	logic [LANES-1:0][KIND_W-1:0] kind_q;
	logic [LANES-1:0]             low;
	logic                         take;

	always_comb begin
		button_index = '0;
		event_kind   = KIND_PRESS;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				button_index = IDX_W'(i);
				event_kind   = kind_q[i];
			end
		end
	end

	assign low        = mask_q & (~mask_q + LANES'(1));
	assign out_valid  = (mask_q != '0);
	assign last_event = out_valid && ((mask_q & ~low) == '0);
	assign take       = out_valid && out_ready;
	assign ev_ready   = !out_valid || (take && last_event);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (ev_load) begin
			mask_q <= ev.mask[LANES-1:0];
		end else if (take) begin
			mask_q <= mask_q & ~low;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_load) begin
			kind_q <= ev.kind[LANES-1:0];
		end
	end

	`BDA_ASSERT_NXT(a_more_follow, take && !last_event, out_valid, "events lost before the last one")
	`BDA_ASSERT_NXT(a_drained, take && last_event && !ev_load, !out_valid, "event repeated after the last one")
	`BDA_ASSERT_NXT(a_hold_stalled, out_valid && !out_ready, out_valid && (button_index == $past(button_index)) && (event_kind == $past(event_kind)), "stalled event changed")

endmodule

>>> rtl/button_debounce_autorepeat.sv
// Button debounce with long-press auto-repeat, top level.
// A request's events pass the input register and then the event register before they are offered.
// Throughput: one request per cycle; a tick with k events holds the next
// eventful request back until its k events have gone out, one per cycle while out_ready is high.
// Reset clears the debounce state, hold counters and pending events, and loads
// the register defaults (debounce 15, long press 500, repeat period 200).
module button_debounce_autorepeat import bda_pkg::*; #(
	parameter int NUM_BUTTONS = DEF_NUM_BUTTONS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic [PIN_W-1:0]      pin_levels,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [IDX_W-1:0]      button_index,
	output logic [KIND_W-1:0]     event_kind,
	output logic                  last_event,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ev_t  ev;
	logic ev_load;
	logic ev_ready;

	assign cfg_ready = 1'b1;

	bda_core #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.pin_levels(pin_levels),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ev_ready  (ev_ready),
		.ev_load   (ev_load),
		.ev        (ev)
	);

	bda_evq #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_evq (
		.clk         (clk),
		.arst_n      (arst_n),
		.ev_load     (ev_load),
		.ev          (ev),
		.ev_ready    (ev_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.button_index(button_index),
		.event_kind  (event_kind),
		.last_event  (last_event)
	);

endmodule
